// ===== sv/osss_pkg.sv =====
// ----------------------------------------------------------------------------
// osss_pkg
// Shared types, constants and bit functions of the scrambled Sobol sampler.
// ----------------------------------------------------------------------------
package osss_pkg;

  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 8;
  localparam int BACK_STAGES   = 5;
  localparam int LANES         = 2;

  localparam logic [31:0] C_HASH_X   = 32'd73856093;
  localparam logic [31:0] C_HASH_Y   = 32'd19349663;
  localparam logic [31:0] C_HASH_DIM = 32'd83492791;
  localparam logic [31:0] C_HASH_MIX = 32'h045d9f3b;
  localparam logic [31:0] C_SCR0     = 32'h3d20adea;
  localparam logic [31:0] C_SCR1     = 32'h05526c56;
  localparam logic [31:0] C_SCR2     = 32'h53a22864;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [30:0] seq_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sample_x;
    logic [31:0] sample_y;
  } out_item_t;

  // front to back: bit-reversed raw points and the two hash products
  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] hx;
    logic [31:0] hy;
  } mid_item_t;

  function automatic logic [31:0] bitrev32(input logic [31:0] v);
    logic [31:0] r;
    for (int k = 0; k < 32; k++) begin
      r[k] = v[31-k];
    end
    return r;
  endfunction

  // second dimension: direction words follow the x+1 polynomial
  function automatic logic [31:0] sobol_dim1(input logic [31:0] gray);
    logic [31:0] word;
    logic [31:0] acc;
    word = 32'h80000000;
    acc  = '0;
    for (int k = 0; k < 32; k++) begin
      if (gray[k]) begin
        acc = acc ^ word;
      end
      word = word ^ (word >> 1);
    end
    return acc;
  endfunction

endpackage

// ===== sv/osss_fifo.sv =====
// ----------------------------------------------------------------------------
// osss_fifo
// Small register queue with push/pop handshake and combinational head.
// ----------------------------------------------------------------------------
module osss_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/osss_front.sv =====
// ----------------------------------------------------------------------------
// osss_front
// Input stage: Gray code, raw Sobol points in reversed bit order, and the
// per-pixel hash products. One register stage in front of the middle queue.
// ----------------------------------------------------------------------------
module osss_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  osss_pkg::in_item_t  in_data,
  input  logic                mid_full,
  output logic                mid_push,
  output osss_pkg::mid_item_t mid_data
);

  logic                fv_r, fv_nxt;
  osss_pkg::mid_item_t fd_r, fd_nxt;
  logic                accept;
  logic [31:0]         gray;

  assign full     = fv_r && mid_full;
  assign accept   = push && !full;
  assign mid_push = fv_r && !mid_full;
  assign mid_data = fd_r;

  always_comb begin
    gray = {1'b0, in_data.seq_index ^ (in_data.seq_index >> 1)};
    // x dimension is a plain bit reversal, so its reversed raw point is gray
    fd_nxt.vx = gray;
    fd_nxt.vy = osss_pkg::bitrev32(osss_pkg::sobol_dim1(gray));
    fd_nxt.hx = 32'({16'd0, in_data.pixel_x} * osss_pkg::C_HASH_X);
    fd_nxt.hy = 32'({16'd0, in_data.pixel_y} * osss_pkg::C_HASH_Y);
    fv_nxt = fv_r;
    if (accept) begin
      fv_nxt = 1'b1;
    end else if (mid_push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fd_r <= fd_nxt;
    end
  end

endmodule

// ===== sv/osss_back.sv =====
// ----------------------------------------------------------------------------
// osss_back
// Five-stage hash and Owen scramble pipeline, both dimensions in parallel.
// Issues from the middle queue only when the result queue has a free slot
// reserved, so the pipeline itself never stalls.
// ----------------------------------------------------------------------------
module osss_back #(
  parameter int OUT_DEPTH = osss_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mid_empty,
  input  osss_pkg::mid_item_t mid_data,
  output logic                mid_pop,
  input  logic                out_pop,
  output logic                res_valid,
  output osss_pkg::out_item_t res_data
);

  localparam int L  = osss_pkg::LANES;
  localparam int NS = osss_pkg::BACK_STAGES;
  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic [NS-1:0] v_r, v_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          issue;

  logic [31:0] s1_v_r  [L];
  logic [31:0] s1_mv_r [L];
  logic [31:0] s1_mh_r [L];
  logic [31:0] s2_w_r  [L];
  logic [15:0] s2_k_r  [L];
  logic [31:0] s3_u_r  [L];
  logic [31:0] s4_u_r  [L];
  logic [31:0] s4_p_r  [L];
  logic [31:0] s5_u_r  [L];
  logic [31:0] s5_q_r  [L];

  logic [31:0] h     [L];
  logic [31:0] t     [L];
  logic [31:0] vin   [L];
  logic [31:0] seed  [L];
  logic [31:0] s1_v_nxt  [L];
  logic [31:0] s1_mv_nxt [L];
  logic [31:0] s1_mh_nxt [L];
  logic [31:0] s2_w_nxt  [L];
  logic [15:0] s2_k_nxt  [L];
  logic [31:0] s3_u_nxt  [L];
  logic [31:0] s4_p_nxt  [L];
  logic [31:0] s5_u_nxt  [L];
  logic [31:0] s5_q_nxt  [L];
  logic [31:0] fin   [L];

  assign issue   = !mid_empty && (cnt_r < CW'(OUT_DEPTH));
  assign mid_pop = issue;

  always_comb begin
    v_nxt   = {v_r[NS-2:0], issue};
    cnt_nxt = cnt_r;
    if (issue && !out_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (out_pop && !issue) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    vin[0] = mid_data.vx;
    vin[1] = mid_data.vy;
    h[0]   = mid_data.hx ^ mid_data.hy;
    h[1]   = mid_data.hx ^ mid_data.hy ^ osss_pkg::C_HASH_DIM;
    for (int l = 0; l < L; l++) begin
      t[l]         = h[l] ^ (h[l] >> 16);
      s1_v_nxt[l]  = vin[l];
      s1_mv_nxt[l] = vin[l] * osss_pkg::C_SCR0;
      s1_mh_nxt[l] = t[l] * osss_pkg::C_HASH_MIX;
      seed[l]      = s1_mh_r[l] ^ (s1_mh_r[l] >> 16);
      s2_w_nxt[l]  = (s1_v_r[l] ^ s1_mv_r[l]) + seed[l];
      s2_k_nxt[l]  = seed[l][31:16] | 16'd1;
      s3_u_nxt[l]  = s2_w_r[l] * {16'd0, s2_k_r[l]};
      s4_p_nxt[l]  = s3_u_r[l] * osss_pkg::C_SCR1;
      s5_u_nxt[l]  = s4_u_r[l] ^ s4_p_r[l];
      s5_q_nxt[l]  = s5_u_nxt[l] * osss_pkg::C_SCR2;
      fin[l]       = osss_pkg::bitrev32(s5_u_r[l] ^ s5_q_r[l]);
    end
  end

  assign res_valid         = v_r[NS-1];
  assign res_data.sample_x = fin[0];
  assign res_data.sample_y = fin[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      cnt_r <= '0;
    end else begin
      v_r   <= v_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_v_r  <= s1_v_nxt;
    s1_mv_r <= s1_mv_nxt;
    s1_mh_r <= s1_mh_nxt;
    s2_w_r  <= s2_w_nxt;
    s2_k_r  <= s2_k_nxt;
    s3_u_r  <= s3_u_nxt;
    s4_u_r  <= s3_u_r;
    s4_p_r  <= s4_p_nxt;
    s5_u_r  <= s5_u_nxt;
    s5_q_r  <= s5_q_nxt;
  end

endmodule

// ===== sv/owen_scrambled_sobol_2d_sampler.sv =====
// ----------------------------------------------------------------------------
// owen_scrambled_sobol_2d_sampler
// Two-dimensional Owen-scrambled Sobol point per pixel and sample index.
// ----------------------------------------------------------------------------
// Push one transaction (pixel_x, pixel_y, seq_index) per cycle while full is
// low; each yields one transaction (sample_x, sample_y) as unsigned 0.32
// fractions, in order. Sustained rate is one item per cycle while pop keeps
// the result queue drained; the path from push to empty going low runs
// through one front register, the middle queue, the five-stage multiply
// pipeline of the scrambler and the result queue. A held-off pop fills the
// result queue and then the middle queue before full rises.
module owen_scrambled_sobol_2d_sampler #(
  parameter int MID_DEPTH = osss_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = osss_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  osss_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output osss_pkg::out_item_t out_data
);

  localparam int MW = $bits(osss_pkg::mid_item_t);
  localparam int OW = $bits(osss_pkg::out_item_t);

  osss_pkg::mid_item_t f_data, m_data;
  osss_pkg::out_item_t r_data;
  logic                f_push, m_full, m_empty, m_pop;
  logic                r_valid, out_pop;
  logic                o_full;
  logic [MW-1:0]       m_rdata;
  logic [OW-1:0]       o_rdata;

  assign out_pop  = pop && !empty;
  assign m_data   = osss_pkg::mid_item_t'(m_rdata);
  assign out_data = osss_pkg::out_item_t'(o_rdata);

  osss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .mid_full (m_full),
    .mid_push (f_push),
    .mid_data (f_data)
  );

  osss_fifo #(
    .WIDTH (MW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_data),
    .pop   (m_pop),
    .full  (m_full),
    .empty (m_empty),
    .rdata (m_rdata)
  );

  osss_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (m_empty),
    .mid_data  (m_data),
    .mid_pop   (m_pop),
    .out_pop   (out_pop),
    .res_valid (r_valid),
    .res_data  (r_data)
  );

  // slot is reserved at issue, so o_full never blocks a push
  osss_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_valid && !o_full),
    .wdata (r_data),
    .pop   (pop),
    .full  (o_full),
    .empty (empty),
    .rdata (o_rdata)
  );

endmodule

// ===== tb/owen_scrambled_sobol_2d_sampler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// owen_scrambled_sobol_2d_sampler_test
// Self-checking bench for the two-dimensional scrambled Sobol sampler: a
// behavioral predictor computes every point, results are compared in order
// while the sender runs in random bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module owen_scrambled_sobol_2d_sampler_test;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 32;
  localparam int         RANDOM_ITEMS = 850;
  localparam int         MAX_REPORTS  = 10;
  localparam logic [1:0] DIM_X        = 2'd0;
  localparam logic [1:0] DIM_Y        = 2'd1;

  typedef enum int {POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_HOLD} pop_mode_t;

  typedef struct {
    osss_pkg::in_item_t  src;
    osss_pkg::out_item_t pt;
  } pending_point_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  osss_pkg::in_item_t  in_data = '0;
  logic                empty;
  logic                pop = 1'b0;
  osss_pkg::out_item_t out_data;

  pending_point_t pending_points[$];
  int             fail_count     = 0;
  int             accepted_count = 0;
  int             checked_count  = 0;
  int             directed_count = 0;
  int             full_cycles    = 0;
  int             cycle_count    = 0;
  int             burst_left     = 0;
  pop_mode_t      pop_mode       = POP_ALWAYS;
  int             pop_mode_left  = 0;
  int             hold_left      = 0;

  owen_scrambled_sobol_2d_sampler u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic logic [31:0] reverse_bits(input logic [31:0] v);
    logic [31:0] r;
    for (int k = 0; k < 32; k++) begin
      r[31-k] = v[k];
    end
    return r;
  endfunction

  function automatic logic [31:0] sobol_point(input logic [30:0] index, input logic [1:0] dim);
    logic [31:0] gray;
    logic [31:0] dir;
    logic [31:0] acc;
    gray = {1'b0, index} ^ ({1'b0, index} >> 1);
    dir  = 32'h8000_0000;
    acc  = '0;
    for (int k = 0; k < 32; k++) begin
      if (gray[k]) begin
        acc ^= (dim == DIM_X) ? (32'h8000_0000 >> k) : dir;
      end
      dir ^= dir >> 1;
    end
    return acc;
  endfunction

  function automatic logic [31:0] dim_seed(input logic [15:0] px, input logic [15:0] py,
                                           input logic [1:0] dim);
    logic [31:0] h;
    h = ({16'h0, px} * osss_pkg::C_HASH_X) ^ ({16'h0, py} * osss_pkg::C_HASH_Y) ^
        ({30'h0, dim} * osss_pkg::C_HASH_DIM);
    h ^= h >> 16;
    h = h * osss_pkg::C_HASH_MIX;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic logic [31:0] nested_scramble(input logic [31:0] raw, input logic [31:0] seed);
    logic [31:0] v;
    v = reverse_bits(raw);
    v ^= v * osss_pkg::C_SCR0;
    v = v + seed;
    v = v * ((seed >> 16) | 32'h1);
    v ^= v * osss_pkg::C_SCR1;
    v ^= v * osss_pkg::C_SCR2;
    return reverse_bits(v);
  endfunction

  function automatic osss_pkg::out_item_t predict_point(input osss_pkg::in_item_t item);
    osss_pkg::out_item_t r;
    r.sample_x = nested_scramble(sobol_point(item.seq_index, DIM_X),
                                 dim_seed(item.pixel_x, item.pixel_y, DIM_X));
    r.sample_y = nested_scramble(sobol_point(item.seq_index, DIM_Y),
                                 dim_seed(item.pixel_x, item.pixel_y, DIM_Y));
    return r;
  endfunction

  // ---------------- monitor and checker ----------------
  task automatic report_failure(input string what, input osss_pkg::in_item_t src,
                                input osss_pkg::out_item_t exp_pt,
                                input osss_pkg::out_item_t got_pt);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t %s: px=%h py=%h idx=%h exp x=%h y=%h got x=%h y=%h", $realtime, what,
               src.pixel_x, src.pixel_y, src.seq_index, exp_pt.sample_x, exp_pt.sample_y,
               got_pt.sample_x, got_pt.sample_y);
    end
  endtask

  always @(posedge clk) begin
    pending_point_t head;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycle_count,
               pending_points.size());
      $display("[owen_scrambled_sobol_2d_sampler] ERROR");
      $finish;
    end
    if (rst_n) begin
      if (full) full_cycles++;
      if (push && !full) begin
        head.src = in_data;
        head.pt  = predict_point(in_data);
        pending_points.push_back(head);
        accepted_count++;
      end
      if (pop && !empty) begin
        if (pending_points.size() == 0) begin
          report_failure("unexpected transaction", '0, '0, out_data);
        end else begin
          head = pending_points.pop_front();
          checked_count++;
          if (out_data.sample_x !== head.pt.sample_x || out_data.sample_y !== head.pt.sample_y)
          begin
            report_failure("mismatch", head.src, head.pt, out_data);
          end
        end
      end
    end
  end

  // ---------------- receiver stall pattern ----------------
  always @(negedge clk) begin
    if (pop_mode_left == 0) begin
      pop_mode      = pop_mode_t'($urandom_range(POP_ALWAYS, POP_HOLD));
      pop_mode_left = $urandom_range(8, 48);
      hold_left     = $urandom_range(10, 30);
    end
    pop_mode_left--;
    case (pop_mode)
      POP_ALWAYS: pop <= 1'b1;
      POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
      POP_RARELY: pop <= ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    endcase
  end

  // ---------------- sender ----------------
  function automatic osss_pkg::in_item_t make_item(input logic [15:0] px,
                                                   input logic [15:0] py,
                                                   input logic [30:0] idx);
    osss_pkg::in_item_t item;
    item.pixel_x   = px;
    item.pixel_y   = py;
    item.seq_index = idx;
    return item;
  endfunction

  task automatic send_item(input osss_pkg::in_item_t item);
    int gap;
    @(negedge clk);
    push    <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (full);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap        = $urandom_range(1, 8);
      @(negedge clk);
      push    <= 1'b0;
      in_data <= osss_pkg::in_item_t'(63'({$urandom, $urandom}));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_index_zero();
    send_item(make_item(16'h0000, 16'h0000, 31'h0));
    send_item(make_item(16'hffff, 16'hffff, 31'h0));
    send_item(make_item(16'h0001, 16'h0000, 31'h0));
    send_item(make_item(16'h0000, 16'h0001, 31'h0));
    send_item(make_item(16'h1234, 16'hbeef, 31'h0));
    directed_count += 5;
  endtask

  task automatic test_field_extremes();
    send_item(make_item(16'hffff, 16'h0000, 31'h7fff_ffff));
    send_item(make_item(16'h0000, 16'hffff, 31'h7fff_ffff));
    send_item(make_item(16'hffff, 16'hffff, 31'h7fff_ffff));
    send_item(make_item(16'h0000, 16'h0000, 31'h7fff_ffff));
    send_item(make_item(16'haaaa, 16'h5555, 31'h5555_5555));
    send_item(make_item(16'h5555, 16'haaaa, 31'h2aaa_aaaa));
    send_item(make_item(16'h8000, 16'h8000, 31'h4000_0000));
    directed_count += 7;
  endtask

  task automatic test_low_indices();
    for (int i = 1; i <= 8; i++) begin
      send_item(make_item(16'h0007, 16'h0003, 31'(i)));
    end
    directed_count += 8;
  endtask

  task automatic test_random_points();
    int          kind;
    int          run_left;
    logic [15:0] px;
    logic [15:0] py;
    logic [30:0] idx;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (run_left == 0) begin
        kind     = $urandom_range(0, 9);
        run_left = $urandom_range(1, 16);
        px       = 16'($urandom_range(0, 16'hffff));
        py       = 16'($urandom_range(0, 16'hffff));
        idx      = 31'($urandom_range(0, 1023));
      end
      run_left--;
      case (kind)
        0, 1, 2, 3: begin
          // consecutive samples of one pixel
          send_item(make_item(px, py, idx));
          idx++;
        end
        4, 5, 6: begin
          send_item(make_item(16'($urandom_range(0, 16'hffff)),
                              16'($urandom_range(0, 16'hffff)), 31'($urandom)));
        end
        7: begin
          send_item(make_item(px, py, 31'h1 << $urandom_range(0, 30)));
        end
        8: begin
          send_item(make_item(px, py, 31'h7fff_ffff - 31'($urandom_range(0, 255))));
        end
        default: begin
          send_item(make_item($urandom_range(0, 1) ? 16'hffff : 16'h0000,
                              $urandom_range(0, 1) ? 16'hffff : 16'h0000, 31'($urandom)));
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    burst_left = $urandom_range(0, 20);
    test_index_zero();
    test_field_extremes();
    test_low_indices();
    test_random_points();
    @(negedge clk);
    push <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d of %0d transactions (%0d directed), full high for %0d cycles",
             checked_count, accepted_count, directed_count, full_cycles);
    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("[owen_scrambled_sobol_2d_sampler] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[owen_scrambled_sobol_2d_sampler] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/osss_pkg.sv
sv/osss_fifo.sv
sv/osss_front.sv
sv/osss_back.sv
sv/owen_scrambled_sobol_2d_sampler.sv
tb/owen_scrambled_sobol_2d_sampler_test.sv
